>>> hdl/caldc_pkg.sv
// Types, constants and helper functions shared by the calendar date counter.
package caldc_pkg;

	localparam logic [1:0] CMD_FWD  = 2'd0;
	localparam logic [1:0] CMD_BACK = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam logic [6:0]  YOC_MAX   = 7'd99;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	localparam logic [4:0]  DAY_MAX   = 5'd31;
	localparam logic [2:0]  DOW_NONE  = 3'd7;

	// floor(x/100) by reciprocal for 27-bit, 21-bit and 14-bit x
	localparam logic [27:0] REC100_W27 = 28'd171798692;
	localparam int          SH100_W27  = 34;
	localparam logic [21:0] REC100_W21 = 22'd2684355;
	localparam int          SH100_W21  = 28;
	localparam logic [12:0] REC100_W14 = 13'd5243;
	localparam int          SH100_W14  = 19;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [26:0] load_value;
	} req_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  day_of_week;
		logic        leap_year;
		logic        load_ok;
	} rsp_t;

	// year is kept together with its century and year of century
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  cent;
		logic [6:0]  yoc;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yoc);
		return (yoc[1:0] == 2'd0) && ((yoc != 7'd0) || (cent[1:0] == 2'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

	// (13*mm+8)/5 mod 7, with January and February as months 13 and 14
	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] off;
		unique case (m)
			4'd1:    off = 3'd0;
			4'd2:    off = 3'd3;
			4'd3:    off = 3'd2;
			4'd4:    off = 3'd5;
			4'd5:    off = 3'd0;
			4'd6:    off = 3'd3;
			4'd7:    off = 3'd5;
			4'd8:    off = 3'd1;
			4'd9:    off = 3'd4;
			4'd10:   off = 3'd6;
			4'd11:   off = 3'd2;
			4'd12:   off = 3'd4;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

	// fold octal digits, since 8 is 1 mod 7
	function automatic logic [2:0] mod7(input logic [9:0] a);
		logic [4:0] f1;
		logic [3:0] f2;
		f1 = 5'(a[2:0]) + 5'(a[5:3]) + 5'(a[8:6]) + 5'(a[9]);
		f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
		return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
	endfunction

endpackage

>>> hdl/caldc_step.sv
// Next-date logic: one day forward or back, load, clear.
module caldc_step (
	input  logic [1:0]      cmd,
	input  logic            zero,
	input  logic            load_ok,
	input  caldc_pkg::date_t ld,
	input  caldc_pkg::date_t cur,
	output caldc_pkg::date_t nxt,
	output logic            ok
);

	logic       cleared;
	logic       leap;
	logic [4:0] len_cur;
	logic [4:0] len_prev;

	always_comb begin
		cleared  = (cur.month == 4'd0);
		leap     = caldc_pkg::is_leap(cur.cent, cur.yoc);
		len_cur  = caldc_pkg::month_len(cur.month, leap);
		len_prev = caldc_pkg::month_len(4'(cur.month - 4'd1), leap);
	end

	always_comb begin
		nxt = cur;
		ok  = 1'b0;
		unique case (cmd)
			caldc_pkg::CMD_FWD: begin
				ok = 1'b1;
				if (cleared) begin
					nxt = cur;
				end else if (cur.year == caldc_pkg::YEAR_MAX && cur.month == caldc_pkg::MONTH_DEC
						&& cur.day == caldc_pkg::DAY_MAX) begin
					nxt = cur;
				end else if (cur.day >= len_cur) begin
					nxt.day = 5'd1;
					if (cur.month == caldc_pkg::MONTH_DEC) begin
						nxt.month = 4'd1;
						nxt.year  = cur.year + 14'd1;
						if (cur.yoc == caldc_pkg::YOC_MAX) begin
							nxt.yoc  = 7'd0;
							nxt.cent = cur.cent + 7'd1;
						end else begin
							nxt.yoc = cur.yoc + 7'd1;
						end
					end else begin
						nxt.month = cur.month + 4'd1;
					end
				end else begin
					nxt.day = cur.day + 5'd1;
				end
			end
			caldc_pkg::CMD_BACK: begin
				ok = 1'b1;
				if (cleared) begin
					nxt = cur;
				end else if (cur.day == 5'd1) begin
					if (cur.month == 4'd1) begin
						if (cur.year > 14'd1) begin
							nxt.year  = cur.year - 14'd1;
							nxt.month = caldc_pkg::MONTH_DEC;
							nxt.day   = caldc_pkg::DAY_MAX;
							if (cur.yoc == 7'd0) begin
								nxt.yoc  = caldc_pkg::YOC_MAX;
								nxt.cent = cur.cent - 7'd1;
							end else begin
								nxt.yoc = cur.yoc - 7'd1;
							end
						end
					end else begin
						nxt.month = cur.month - 4'd1;
						nxt.day   = len_prev;
					end
				end else begin
					nxt.day = cur.day - 5'd1;
				end
			end
			caldc_pkg::CMD_LOAD: begin
				if (zero) begin
					nxt = '0;
				end else if (load_ok) begin
					nxt = ld;
					ok  = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> hdl/caldc_wday.sv
// Weekday and leap flag of a date, Zeller form split by century.
module caldc_wday (
	input  caldc_pkg::date_t date,
	output logic [2:0]       day_of_week,
	output logic             leap_year
);

	logic       cleared;
	logic [6:0] jc;
	logic [6:0] kc;
	logic [9:0] sum;

	always_comb begin
		cleared = (date.month == 4'd0);
		if (date.month < 4'd3) begin
			if (date.yoc == 7'd0) begin
				kc = caldc_pkg::YOC_MAX;
				jc = date.cent + 7'd3;
			end else begin
				kc = date.yoc - 7'd1;
				jc = date.cent + 7'd4;
			end
		end else begin
			kc = date.yoc;
			jc = date.cent + 7'd4;
		end
		sum = {1'b0, jc, 2'b00} + 10'(jc) + 10'(jc[6:2]) + 10'(kc) + 10'(kc[6:2])
			+ 10'(caldc_pkg::month_offset(date.month)) + 10'(date.day);
		day_of_week = cleared ? caldc_pkg::DOW_NONE : caldc_pkg::mod7(sum);
		leap_year   = !cleared && caldc_pkg::is_leap(date.cent, date.yoc);
	end

endmodule

>>> hdl/calendar_date_counter_core.sv
// Top level of the calendar date counter: load decode pipeline, date state, result stage.
//
// Request channel req_valid/req_stall/req_data carries one item: cmd and load_value.
// Response channel rsp_valid/rsp_stall/rsp_data returns one result per item, in order.
// An item moves on a rising edge with valid high and stall low on its channel.
// A request passes through every stage and the result register before its result shows on rsp_valid.
// Throughput: one item per cycle, unless rsp_stall holds a full pipeline.
// Stages 1 to 4 split load_value into year, century, month and day by constant
// reciprocal multiplies, stage 5 updates the stored date, stage 6 derives the
// weekday and leap flag, and the result register drives rsp_data.
// Each stage holds its item only while the next stage is full and held, so when
// rsp_stall is high, empty stages still fill and req_stall rises only once the
// whole pipeline is full. A held result does not change.
// Reset clears the stored date (month 0, weekday 7) and empties the pipeline.
module calendar_date_counter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  caldc_pkg::req_t   req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output caldc_pkg::rsp_t   rsp_data
);

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_out;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, rsp_vld_q;

	caldc_pkg::req_t  req_s1;
	logic [1:0]       cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic             zero_s2, zero_s3, zero_s4, zero_s5;
	logic [6:0]       vlo_s2;
	logic [20:0]      h_s2;
	logic [6:0]       d_s3, hlo_s3;
	logic [13:0]      y_s3;
	logic [6:0]       d_s4, m_s4;
	logic [13:0]      y_s4;
	logic [7:0]       c_s4;
	logic             ok_s5;
	caldc_pkg::date_t ld_s5;
	caldc_pkg::date_t cur_q;
	caldc_pkg::date_t date_s6;
	logic             ok_s6;
	caldc_pkg::rsp_t  rsp_q;

	logic [54:0]      prod1;
	logic [20:0]      h1;
	logic [42:0]      prod2;
	logic [13:0]      y2;
	logic [13:0]      t2;
	logic [6:0]       d2;
	logic [26:0]      prod3;
	logic [7:0]       c3;
	logic [13:0]      t3;
	logic [6:0]       m3;
	logic [13:0]      t4;
	logic             ok4;
	caldc_pkg::date_t ld4;
	caldc_pkg::date_t nxt5;
	logic             ok5;
	logic [2:0]       dow6;
	logic             leap6;

	always_comb begin
		rdy_out = !rsp_vld_q || !rsp_stall;
		rdy_s6  = !vld_s6 || rdy_out;
		rdy_s5  = !vld_s5 || rdy_s6;
		rdy_s4  = !vld_s4 || rdy_s5;
		rdy_s3  = !vld_s3 || rdy_s4;
		rdy_s2  = !vld_s2 || rdy_s3;
		rdy_s1  = !vld_s1 || rdy_s2;
	end

	assign req_stall = !rdy_s1;
	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		prod1 = 55'(req_s1.load_value) * 55'(caldc_pkg::REC100_W27);
		h1    = prod1[caldc_pkg::SH100_W27 +: 21];

		prod2 = 43'(h_s2) * 43'(caldc_pkg::REC100_W21);
		y2    = prod2[caldc_pkg::SH100_W21 +: 14];
		t2    = 14'(h_s2[6:0]) * 14'd100;
		d2    = vlo_s2 - t2[6:0];

		prod3 = 27'(y_s3) * 27'(caldc_pkg::REC100_W14);
		c3    = prod3[caldc_pkg::SH100_W14 +: 8];
		t3    = 14'(y_s3[6:0]) * 14'd100;
		m3    = hlo_s3 - t3[6:0];

		t4         = 14'(c_s4[6:0]) * 14'd100;
		ld4.year   = y_s4;
		ld4.cent   = c_s4[6:0];
		ld4.yoc    = y_s4[6:0] - t4[6:0];
		ld4.month  = m_s4[3:0];
		ld4.day    = d_s4[4:0];
		ok4        = !zero_s4 && (m_s4 >= 7'd1) && (m_s4 <= 7'd12) && (d_s4 >= 7'd1)
			&& (d_s4 <= 7'd31) && (y_s4 <= caldc_pkg::YEAR_MAX);
	end

	caldc_step u_step (
		.cmd     (cmd_s5),
		.zero    (zero_s5),
		.load_ok (ok_s5),
		.ld      (ld_s5),
		.cur     (cur_q),
		.nxt     (nxt5),
		.ok      (ok5)
	);

	caldc_wday u_wday (
		.date        (date_s6),
		.day_of_week (dow6),
		.leap_year   (leap6)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			rsp_vld_q <= 1'b0;
			cur_q     <= '0;
		end else begin
			if (rdy_s1) vld_s1 <= req_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_out) rsp_vld_q <= vld_s6;
			if (vld_s5 && rdy_s6) cur_q <= nxt5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			req_s1 <= req_data;
		end
		if (rdy_s2 && vld_s1) begin
			cmd_s2  <= req_s1.cmd;
			zero_s2 <= (req_s1.load_value == 27'd0);
			vlo_s2  <= req_s1.load_value[6:0];
			h_s2    <= h1;
		end
		if (rdy_s3 && vld_s2) begin
			cmd_s3  <= cmd_s2;
			zero_s3 <= zero_s2;
			d_s3    <= d2;
			hlo_s3  <= h_s2[6:0];
			y_s3    <= y2;
		end
		if (rdy_s4 && vld_s3) begin
			cmd_s4  <= cmd_s3;
			zero_s4 <= zero_s3;
			d_s4    <= d_s3;
			m_s4    <= m3;
			y_s4    <= y_s3;
			c_s4    <= c3;
		end
		if (rdy_s5 && vld_s4) begin
			cmd_s5  <= cmd_s4;
			zero_s5 <= zero_s4;
			ok_s5   <= ok4;
			ld_s5   <= ld4;
		end
		if (rdy_s6 && vld_s5) begin
			date_s6 <= nxt5;
			ok_s6   <= ok5;
		end
		if (rdy_out && vld_s6) begin
			rsp_q.year        <= date_s6.year;
			rsp_q.month       <= date_s6.month;
			rsp_q.day         <= date_s6.day;
			rsp_q.day_of_week <= dow6;
			rsp_q.leap_year   <= leap6;
			rsp_q.load_ok     <= ok_s6;
		end
	end

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s5 && rdy_s6) |=> $stable(cur_q))
		else $error("date changed with no item leaving the update stage");

	a_cleared_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.month == 4'd0) |-> (cur_q.year == 14'd0 && cur_q.day == 5'd0))
		else $error("cleared date holds a nonzero year or day");

	a_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.month != 4'd0) |-> (cur_q.month <= caldc_pkg::MONTH_DEC
		&& cur_q.year <= caldc_pkg::YEAR_MAX
		&& cur_q.year == 14'(14'(cur_q.cent) * 14'd100 + 14'(cur_q.yoc))))
		else $error("stored year disagrees with its century split");

	a_rsp_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q |-> ((rsp_q.month == 4'd0)
		== (rsp_q.day_of_week == caldc_pkg::DOW_NONE)))
		else $error("weekday code and cleared month disagree");

endmodule
